@@ rtl/core/lcab_pkg.sv @@
// lcab_pkg: sizes, codes, controller/datapath command types and helper functions
// for the binary-lifting lowest common ancestor engine
// no dependencies
`timescale 1ns / 1ps

package lcab_pkg;

	// tree size and lifting depth
	localparam int MAX_NODES = 1024;
	localparam int TOP_LEVEL = 10;
	localparam int LEVELS    = TOP_LEVEL + 1;
	localparam int SLOTS     = MAX_NODES + 1;

	// field widths
	localparam int OPCODE_W = 2;
	localparam int NODE_W   = 11;
	localparam int DEPTH_W  = 10;

	localparam int LEVEL_W   = $clog2(LEVELS + 1);
	localparam int ANC_DEPTH = LEVELS * SLOTS;
	localparam int ANC_AW    = $clog2(ANC_DEPTH);
	localparam int DEP_AW    = $clog2(SLOTS);

	// register port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_NODE_COUNT = '0;
	localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(1);

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_B_RD1,
		ST_B_RD2,
		ST_B_WR,
		ST_Q_DRD,
		ST_Q_SWAP,
		ST_L1,
		ST_L1_ANC,
		ST_L1_DEP,
		ST_CHK,
		ST_L2_RD,
		ST_L2_CMP,
		ST_FIN_RD,
		ST_FIN_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LATCH,
		DP_LOAD,
		DP_B_RD1,
		DP_B_RD2,
		DP_B_WR,
		DP_Q_DRD,
		DP_Q_SWAP,
		DP_L1_RD,
		DP_L1_B,
		DP_L1_D,
		DP_RES_A,
		DP_L2_RD,
		DP_L2_CMP,
		DP_FIN_RD,
		DP_FIN,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic [LEVEL_W-1:0]  level;
		logic [NODE_W-1:0]   node;
		logic [ANC_AW-1:0]   clr_addr;
	} dp_cmd_t;

	typedef struct packed {
		logic lift;
		logic same;
	} dp_status_t;

	// node numbers beyond the table fall back to the sentinel
	function automatic logic [NODE_W-1:0] node_of(input logic [NODE_W-1:0] v);
		node_of = (32'(v) <= MAX_NODES) ? v : '0;
	endfunction

	// ancestor store is level-major: level * SLOTS + node
	function automatic logic [ANC_AW-1:0] anc_addr(input logic [LEVEL_W-1:0] lvl,
			input logic [NODE_W-1:0] node);
		anc_addr = ANC_AW'(lvl) * ANC_AW'(SLOTS) + ANC_AW'(node);
	endfunction

endpackage

@@ rtl/core/lcab_item_if.sv @@
// lcab_item_if: input channel carrying load, build and query transactions
// depends on lcab_pkg
`timescale 1ns / 1ps

interface lcab_item_if;
	logic                          valid;
	logic                          ready;
	logic [lcab_pkg::OPCODE_W-1:0] opcode;
	logic [lcab_pkg::NODE_W-1:0]   node_index;
	logic [lcab_pkg::NODE_W-1:0]   parent_index;
	logic [lcab_pkg::DEPTH_W-1:0]  node_depth;
	logic [lcab_pkg::NODE_W-1:0]   query_a;
	logic [lcab_pkg::NODE_W-1:0]   query_b;

	modport source (
		output valid, opcode, node_index, parent_index, node_depth, query_a, query_b,
		input  ready
	);

	modport sink (
		input  valid, opcode, node_index, parent_index, node_depth, query_a, query_b,
		output ready
	);
endinterface

@@ rtl/core/lcab_result_if.sv @@
// lcab_result_if: output channel carrying one common ancestor per query
// depends on lcab_pkg
`timescale 1ns / 1ps

interface lcab_result_if;
	logic                        valid;
	logic                        ready;
	logic [lcab_pkg::NODE_W-1:0] common_ancestor;

	modport source (
		output valid, common_ancestor,
		input  ready
	);

	modport sink (
		input  valid, common_ancestor,
		output ready
	);
endinterface

@@ rtl/core/lcab_ram.sv @@
// lcab_ram: generic single-write, dual-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module lcab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	output logic [WIDTH-1:0]         rdata0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

@@ rtl/core/lcab_dp.sv @@
// lcab_dp: datapath with the ancestor and depth memories, node and depth registers
// depends on lcab_pkg, lcab_ram
`timescale 1ns / 1ps

module lcab_dp (
	input  logic                          clk,
	input  lcab_pkg::dp_cmd_t             cmd,
	output lcab_pkg::dp_status_t          status,
	input  logic [lcab_pkg::NODE_W-1:0]   node_index,
	input  logic [lcab_pkg::NODE_W-1:0]   parent_index,
	input  logic [lcab_pkg::DEPTH_W-1:0]  node_depth,
	input  logic [lcab_pkg::NODE_W-1:0]   query_a,
	input  logic [lcab_pkg::NODE_W-1:0]   query_b,
	output logic [lcab_pkg::NODE_W-1:0]   common_ancestor
);

	logic [lcab_pkg::NODE_W-1:0]  lnode_q, lpar_q, a_q, b_q, res_q, out_q;
	logic [lcab_pkg::DEPTH_W-1:0] ldep_q, da_q, db_q;

	logic                         anc_we;
	logic [lcab_pkg::ANC_AW-1:0]  anc_waddr, anc_raddr0, anc_raddr1;
	logic [lcab_pkg::NODE_W-1:0]  anc_wdata, anc_rd0, anc_rd1;
	logic                         dep_we;
	logic [lcab_pkg::DEP_AW-1:0]  dep_raddr0, dep_raddr1;
	logic [lcab_pkg::DEPTH_W-1:0] dep_rd0, dep_rd1;
	logic [lcab_pkg::DEPTH_W-1:0] da_new, db_new;
	logic [lcab_pkg::DEPTH_W:0]   diff;
	logic [lcab_pkg::LEVEL_W-1:0] level_m1;
	logic                         load_ok;

	assign level_m1 = cmd.level - lcab_pkg::LEVEL_W'(1);
	assign load_ok  = (lnode_q != '0) && (32'(lnode_q) <= lcab_pkg::MAX_NODES);

	// depth distance, top bit set when the b side is shallower
	assign diff = {1'b0, db_q} - {1'b0, da_q};
	assign status.lift = !diff[lcab_pkg::DEPTH_W] &&
		(32'(diff[lcab_pkg::DEPTH_W-1:0]) >= (32'd1 << cmd.level));
	assign status.same = (a_q == b_q);

	// sentinel node has depth 0
	assign da_new = (a_q == '0) ? '0 : dep_rd0;
	assign db_new = (b_q == '0) ? '0 : dep_rd1;

	always_comb begin
		anc_we     = 1'b0;
		anc_waddr  = cmd.clr_addr;
		anc_wdata  = '0;
		anc_raddr0 = lcab_pkg::anc_addr(cmd.level, a_q);
		anc_raddr1 = lcab_pkg::anc_addr(cmd.level, b_q);
		dep_we     = 1'b0;
		dep_raddr0 = lcab_pkg::DEP_AW'(a_q);
		dep_raddr1 = lcab_pkg::DEP_AW'(b_q);
		case (cmd.op)
			lcab_pkg::DP_CLEAR: begin
				anc_we = 1'b1;
			end
			lcab_pkg::DP_LOAD: begin
				anc_we    = load_ok;
				anc_waddr = lcab_pkg::anc_addr('0, lnode_q);
				anc_wdata = lpar_q;
				dep_we    = load_ok;
			end
			lcab_pkg::DP_B_RD1: begin
				anc_raddr0 = lcab_pkg::anc_addr(level_m1, cmd.node);
			end
			lcab_pkg::DP_B_RD2: begin
				anc_raddr0 = lcab_pkg::anc_addr(level_m1, anc_rd0);
			end
			lcab_pkg::DP_B_WR: begin
				anc_we    = 1'b1;
				anc_waddr = lcab_pkg::anc_addr(cmd.level, cmd.node);
				anc_wdata = anc_rd0;
			end
			lcab_pkg::DP_L1_B: begin
				dep_raddr1 = lcab_pkg::DEP_AW'(anc_rd1);
			end
			lcab_pkg::DP_FIN_RD: begin
				anc_raddr0 = lcab_pkg::anc_addr('0, a_q);
			end
			default: begin
			end
		endcase
	end

	lcab_ram #(
		.WIDTH (lcab_pkg::NODE_W),
		.DEPTH (lcab_pkg::ANC_DEPTH)
	) u_anc_ram (
		.clk    (clk),
		.we     (anc_we),
		.waddr  (anc_waddr),
		.wdata  (anc_wdata),
		.raddr0 (anc_raddr0),
		.rdata0 (anc_rd0),
		.raddr1 (anc_raddr1),
		.rdata1 (anc_rd1)
	);

	lcab_ram #(
		.WIDTH (lcab_pkg::DEPTH_W),
		.DEPTH (lcab_pkg::SLOTS)
	) u_dep_ram (
		.clk    (clk),
		.we     (dep_we),
		.waddr  (lcab_pkg::DEP_AW'(lnode_q)),
		.wdata  (ldep_q),
		.raddr0 (dep_raddr0),
		.rdata0 (dep_rd0),
		.raddr1 (dep_raddr1),
		.rdata1 (dep_rd1)
	);

	always_ff @(posedge clk) begin
		case (cmd.op)
			lcab_pkg::DP_LATCH: begin
				lnode_q <= node_index;
				lpar_q  <= lcab_pkg::node_of(parent_index);
				ldep_q  <= node_depth;
				a_q     <= lcab_pkg::node_of(query_a);
				b_q     <= lcab_pkg::node_of(query_b);
			end
			lcab_pkg::DP_Q_SWAP: begin
				// keep the deeper node on the b side
				if (da_new > db_new) begin
					a_q  <= b_q;
					b_q  <= a_q;
					da_q <= db_new;
					db_q <= da_new;
				end else begin
					da_q <= da_new;
					db_q <= db_new;
				end
			end
			lcab_pkg::DP_L1_B: begin
				b_q <= anc_rd1;
			end
			lcab_pkg::DP_L1_D: begin
				db_q <= db_new;
			end
			lcab_pkg::DP_RES_A: begin
				res_q <= a_q;
			end
			lcab_pkg::DP_L2_CMP: begin
				if (anc_rd0 != anc_rd1) begin
					a_q <= anc_rd0;
					b_q <= anc_rd1;
				end
			end
			lcab_pkg::DP_FIN: begin
				res_q <= anc_rd0;
			end
			lcab_pkg::DP_OUT: begin
				out_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	assign common_ancestor = out_q;

endmodule

@@ rtl/core/lcab_ctrl.sv @@
// lcab_ctrl: sequencer for memory clear, load, table build and lifting query
// depends on lcab_pkg
`timescale 1ns / 1ps

module lcab_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [lcab_pkg::NODE_W-1:0]    node_count,
	input  logic                           item_valid,
	input  logic [lcab_pkg::OPCODE_W-1:0]  item_opcode,
	output logic                           item_ready,
	output logic                           result_valid,
	input  logic                           result_ready,
	output lcab_pkg::dp_cmd_t              cmd,
	input  lcab_pkg::dp_status_t           status
);

	lcab_pkg::state_t             state_q, state_d;
	logic [lcab_pkg::LEVEL_W-1:0] level_q, level_d;
	logic [lcab_pkg::NODE_W-1:0]  node_q, node_d;
	logic [lcab_pkg::ANC_AW-1:0]  clr_q, clr_d;
	logic                         out_valid_q, out_valid_d;
	logic [lcab_pkg::NODE_W-1:0]  limit;
	logic                         accept;

	localparam logic [lcab_pkg::LEVEL_W-1:0] LVL_TOP = lcab_pkg::LEVEL_W'(lcab_pkg::TOP_LEVEL);
	localparam logic [lcab_pkg::LEVEL_W-1:0] LVL_ONE = lcab_pkg::LEVEL_W'(1);
	localparam logic [lcab_pkg::NODE_W-1:0]  NODE_ONE = lcab_pkg::NODE_W'(1);
	localparam logic [lcab_pkg::ANC_AW-1:0]  CLR_LAST =
		lcab_pkg::ANC_AW'(lcab_pkg::ANC_DEPTH - 1);

	assign limit = (32'(node_count) > lcab_pkg::MAX_NODES) ?
		lcab_pkg::NODE_W'(lcab_pkg::MAX_NODES) : node_count;

	assign item_ready   = (state_q == lcab_pkg::ST_IDLE);
	assign accept       = item_ready && item_valid;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcab_pkg::ST_CLEAR;
			level_q     <= '0;
			node_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			level_q     <= level_d;
			node_q      <= node_d;
			clr_q       <= clr_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		level_d      = level_q;
		node_d       = node_q;
		clr_d        = clr_q;
		out_valid_d  = out_valid_q && !result_ready;
		cmd.op       = lcab_pkg::DP_NOP;
		cmd.level    = level_q;
		cmd.node     = node_q;
		cmd.clr_addr = clr_q;
		case (state_q)
			lcab_pkg::ST_CLEAR: begin
				cmd.op = lcab_pkg::DP_CLEAR;
				clr_d  = clr_q + lcab_pkg::ANC_AW'(1);
				if (clr_q == CLR_LAST) begin
					state_d = lcab_pkg::ST_IDLE;
				end
			end
			lcab_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.op = lcab_pkg::DP_LATCH;
					case (lcab_pkg::op_t'(item_opcode))
						lcab_pkg::OP_LOAD: begin
							state_d = lcab_pkg::ST_LOAD;
						end
						lcab_pkg::OP_BUILD: begin
							level_d = LVL_ONE;
							node_d  = NODE_ONE;
							if (limit != '0) begin
								state_d = lcab_pkg::ST_B_RD1;
							end
						end
						lcab_pkg::OP_QUERY: begin
							state_d = lcab_pkg::ST_Q_DRD;
						end
						default: begin
						end
					endcase
				end
			end
			lcab_pkg::ST_LOAD: begin
				cmd.op  = lcab_pkg::DP_LOAD;
				state_d = lcab_pkg::ST_IDLE;
			end
			lcab_pkg::ST_B_RD1: begin
				cmd.op  = lcab_pkg::DP_B_RD1;
				state_d = lcab_pkg::ST_B_RD2;
			end
			lcab_pkg::ST_B_RD2: begin
				cmd.op  = lcab_pkg::DP_B_RD2;
				state_d = lcab_pkg::ST_B_WR;
			end
			lcab_pkg::ST_B_WR: begin
				cmd.op  = lcab_pkg::DP_B_WR;
				state_d = lcab_pkg::ST_B_RD1;
				if (node_q == limit) begin
					node_d = NODE_ONE;
					if (level_q == LVL_TOP) begin
						state_d = lcab_pkg::ST_IDLE;
					end else begin
						level_d = level_q + LVL_ONE;
					end
				end else begin
					node_d = node_q + NODE_ONE;
				end
			end
			lcab_pkg::ST_Q_DRD: begin
				cmd.op  = lcab_pkg::DP_Q_DRD;
				state_d = lcab_pkg::ST_Q_SWAP;
			end
			lcab_pkg::ST_Q_SWAP: begin
				cmd.op  = lcab_pkg::DP_Q_SWAP;
				level_d = LVL_TOP;
				state_d = lcab_pkg::ST_L1;
			end
			// first pass: lift b by powers of two until the depths match
			lcab_pkg::ST_L1: begin
				if (status.lift) begin
					cmd.op  = lcab_pkg::DP_L1_RD;
					state_d = lcab_pkg::ST_L1_ANC;
				end else if (level_q == '0) begin
					state_d = lcab_pkg::ST_CHK;
				end else begin
					level_d = level_q - LVL_ONE;
				end
			end
			lcab_pkg::ST_L1_ANC: begin
				cmd.op  = lcab_pkg::DP_L1_B;
				state_d = lcab_pkg::ST_L1_DEP;
			end
			lcab_pkg::ST_L1_DEP: begin
				cmd.op = lcab_pkg::DP_L1_D;
				if (level_q == '0) begin
					state_d = lcab_pkg::ST_CHK;
				end else begin
					level_d = level_q - LVL_ONE;
					state_d = lcab_pkg::ST_L1;
				end
			end
			lcab_pkg::ST_CHK: begin
				if (status.same) begin
					cmd.op  = lcab_pkg::DP_RES_A;
					state_d = lcab_pkg::ST_DONE;
				end else begin
					level_d = LVL_TOP;
					state_d = lcab_pkg::ST_L2_RD;
				end
			end
			// second pass: lift both while their ancestors differ
			lcab_pkg::ST_L2_RD: begin
				cmd.op  = lcab_pkg::DP_L2_RD;
				state_d = lcab_pkg::ST_L2_CMP;
			end
			lcab_pkg::ST_L2_CMP: begin
				cmd.op = lcab_pkg::DP_L2_CMP;
				if (level_q == '0) begin
					state_d = lcab_pkg::ST_FIN_RD;
				end else begin
					level_d = level_q - LVL_ONE;
					state_d = lcab_pkg::ST_L2_RD;
				end
			end
			lcab_pkg::ST_FIN_RD: begin
				cmd.op  = lcab_pkg::DP_FIN_RD;
				state_d = lcab_pkg::ST_FIN_WAIT;
			end
			lcab_pkg::ST_FIN_WAIT: begin
				cmd.op  = lcab_pkg::DP_FIN;
				state_d = lcab_pkg::ST_DONE;
			end
			lcab_pkg::ST_DONE: begin
				// hand over once the output register is free
				if (!out_valid_q || result_ready) begin
					cmd.op      = lcab_pkg::DP_OUT;
					out_valid_d = 1'b1;
					state_d     = lcab_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lcab_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/lca_binary_lifting.sv @@
// lca_binary_lifting: top level, register port, sequencer and datapath
// depends on lcab_pkg, lcab_item_if, lcab_result_if, lcab_ctrl, lcab_dp
//
//  port     dir   handshake        carries
//  item     in    valid/ready      opcode, node_index, parent_index, node_depth,
//                                  query_a, query_b
//  result   out   valid/ready      common_ancestor (one per query transaction)
//  apb      in    psel/penable     node_count at byte address 0
//
// build fills levels 1 to TOP_LEVEL for nodes 1 to min(node_count, MAX_NODES)
// query lifts the deeper node level by level, then both while their ancestors
// differ; each lift waits on a registered read of the ancestor memory
// after reset the ancestor memory is zeroed, one entry a cycle, all
// (TOP_LEVEL+1) * (MAX_NODES+1) = 11275 entries; item.ready stays low meanwhile
// a finished result waits in the output register while the next transaction enters
`timescale 1ns / 1ps

module lca_binary_lifting (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lcab_pkg::APB_AW-1:0]   paddr,
	input  logic [lcab_pkg::APB_DW-1:0]   pwdata,
	output logic [lcab_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	lcab_item_if.sink                     item,
	lcab_result_if.source                 result
);

	logic [lcab_pkg::NODE_W-1:0] node_count_q;
	logic                        reg_hit;
	lcab_pkg::dp_cmd_t           cmd;
	lcab_pkg::dp_status_t        status;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[lcab_pkg::APB_AW-1:2] == lcab_pkg::REG_NODE_COUNT);
	assign prdata  = reg_hit ? lcab_pkg::APB_DW'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= lcab_pkg::NODE_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			node_count_q <= pwdata[lcab_pkg::NODE_W-1:0];
		end
	end

	lcab_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.node_count   (node_count_q),
		.item_valid   (item.valid),
		.item_opcode  (item.opcode),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.status       (status)
	);

	lcab_dp u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.status          (status),
		.node_index      (item.node_index),
		.parent_index    (item.parent_index),
		.node_depth      (item.node_depth),
		.query_a         (item.query_a),
		.query_b         (item.query_b),
		.common_ancestor (result.common_ancestor)
	);

endmodule

@@ dv/lca_binary_lifting_tb.sv @@
// lca_binary_lifting_tb: self-checking testbench for the binary-lifting lca engine
// drives load, build and query transactions, predicts each common ancestor in a local model
// depends on lcab_pkg, lcab_item_if, lcab_result_if and lca_binary_lifting
`timescale 1ns / 1ps

module lca_binary_lifting_tb;

	localparam int STALL_LIMIT = 200000;

	typedef struct {
		lcab_pkg::op_t                opcode;
		logic [lcab_pkg::NODE_W-1:0]  node_index;
		logic [lcab_pkg::NODE_W-1:0]  parent_index;
		logic [lcab_pkg::DEPTH_W-1:0] node_depth;
		logic [lcab_pkg::NODE_W-1:0]  query_a;
		logic [lcab_pkg::NODE_W-1:0]  query_b;
	} tree_op_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [lcab_pkg::APB_AW-1:0] paddr;
	logic [lcab_pkg::APB_DW-1:0] pwdata;
	logic [lcab_pkg::APB_DW-1:0] prdata;
	logic                        pready;

	lcab_item_if   item_bus ();
	lcab_result_if res_bus ();

	lca_binary_lifting dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_bus),
		.result  (res_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// local copy of the engine state
	logic [lcab_pkg::NODE_W-1:0]  anc_mdl [0:lcab_pkg::LEVELS-1][0:lcab_pkg::SLOTS-1];
	logic [lcab_pkg::DEPTH_W-1:0] dep_mdl [0:lcab_pkg::SLOTS-1];
	logic [lcab_pkg::NODE_W-1:0]  nc_mdl;
	logic [lcab_pkg::NODE_W-1:0]  pending_lca [$];

	// stimulus side
	tree_op_t op_queue [$];
	bit       known [0:lcab_pkg::MAX_NODES];
	int       known_ids [$];
	int       tree_ids [$];

	int   idle_pct = 0;
	int   stall_pct = 0;
	int   hold_request = 0;
	int   hold_left = 0;
	bit   hold_used = 1'b0;
	logic item_fire = 1'b0;
	int   idle_cycles = 0;
	int   errors = 0;

	function automatic int as_node(input logic [lcab_pkg::NODE_W-1:0] v);
		return (v <= lcab_pkg::MAX_NODES) ? int'(v) : 0;
	endfunction

	function automatic int depth_at(input int n);
		return (n == 0) ? 0 : int'(dep_mdl[n]);
	endfunction

	function automatic void lift_table();
		int lim;
		lim = (nc_mdl > lcab_pkg::MAX_NODES) ? lcab_pkg::MAX_NODES : int'(nc_mdl);
		for (int k = 1; k < lcab_pkg::LEVELS; k++)
			for (int v = 1; v <= lim; v++)
				anc_mdl[k][v] = anc_mdl[k-1][anc_mdl[k-1][v]];
	endfunction

	function automatic logic [lcab_pkg::NODE_W-1:0] lowest_common(input int a, input int b);
		int t;
		int d;
		if (depth_at(a) > depth_at(b)) begin
			t = a;
			a = b;
			b = t;
		end
		// bring the deeper node up to the depth of the other
		for (int i = lcab_pkg::TOP_LEVEL; i >= 0; i--) begin
			d = depth_at(b) - depth_at(a);
			if (d >= (1 << i))
				b = int'(anc_mdl[i][b]);
		end
		if (a == b)
			return lcab_pkg::NODE_W'(a);
		for (int i = lcab_pkg::TOP_LEVEL; i >= 0; i--) begin
			if (anc_mdl[i][a] != anc_mdl[i][b]) begin
				a = int'(anc_mdl[i][a]);
				b = int'(anc_mdl[i][b]);
			end
		end
		return anc_mdl[0][a];
	endfunction

	function automatic void absorb_item(input lcab_pkg::op_t op,
			input logic [lcab_pkg::NODE_W-1:0] n, input logic [lcab_pkg::NODE_W-1:0] p,
			input logic [lcab_pkg::DEPTH_W-1:0] d, input logic [lcab_pkg::NODE_W-1:0] qa,
			input logic [lcab_pkg::NODE_W-1:0] qb);
		case (op)
		lcab_pkg::OP_LOAD: begin
			if (n != 0 && n <= lcab_pkg::MAX_NODES) begin
				anc_mdl[0][n] = lcab_pkg::NODE_W'(as_node(p));
				dep_mdl[n] = d;
			end
		end
		lcab_pkg::OP_BUILD: lift_table();
		lcab_pkg::OP_QUERY: pending_lca = {pending_lca, lowest_common(as_node(qa), as_node(qb))};
		default: ;
		endcase
	endfunction

	// stimulus builders
	function automatic void push_raw(input lcab_pkg::op_t op, input int n, input int p,
			input int d, input int a, input int b);
		tree_op_t t;
		t.opcode       = op;
		t.node_index   = lcab_pkg::NODE_W'(n);
		t.parent_index = lcab_pkg::NODE_W'(p);
		t.node_depth   = lcab_pkg::DEPTH_W'(d);
		t.query_a      = lcab_pkg::NODE_W'(a);
		t.query_b      = lcab_pkg::NODE_W'(b);
		if (op == lcab_pkg::OP_LOAD && t.node_index != 0 &&
				t.node_index <= lcab_pkg::MAX_NODES && !known[t.node_index]) begin
			known[t.node_index] = 1'b1;
			known_ids = {known_ids, int'(t.node_index)};
		end
		op_queue = {op_queue, t};
	endfunction

	function automatic void push_load(input int n, input int p, input int d);
		push_raw(lcab_pkg::OP_LOAD, n, p, d, $urandom(), $urandom());
	endfunction

	function automatic void push_query(input int a, input int b);
		push_raw(lcab_pkg::OP_QUERY, $urandom(), $urandom(), $urandom(), a, b);
	endfunction

	function automatic void push_build();
		push_raw(lcab_pkg::OP_BUILD, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom());
	endfunction

	// queries only name loaded nodes, the sentinel or numbers beyond the table
	function automatic int pick_node();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return tree_ids[$urandom_range(tree_ids.size() - 1)];
		if (r < 90)
			return known_ids[$urandom_range(known_ids.size() - 1)];
		if (r < 94)
			return 0;
		return $urandom_range(2047, lcab_pkg::MAX_NODES + 1);
	endfunction

	function automatic int any_known();
		return known_ids[$urandom_range(known_ids.size() - 1)];
	endfunction

	function automatic void add_noise();
		if ($urandom_range(99) < 10) begin
			case ($urandom_range(3))
			0: push_raw(lcab_pkg::OP_NONE, $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom());
			1: push_raw(lcab_pkg::OP_LOAD,
					$urandom_range(1) ? 0 : $urandom_range(2047, lcab_pkg::MAX_NODES + 1),
					$urandom(), $urandom(), $urandom(), $urandom());
			// relink a loaded node; parent stays inside the loaded set or off the table
			2: push_load(any_known(), $urandom_range(1) ? any_known() :
					$urandom_range(2047, lcab_pkg::MAX_NODES + 1), $urandom());
			default: push_build();
			endcase
		end
	endfunction

	function automatic void plant_tree(input int nc, input int m, input int nq, input bit deep);
		int lim;
		int base;
		int off;
		int span;
		int p;
		int a;
		int dd [$];
		lim = (nc == 0) ? 8 : ((nc > lcab_pkg::MAX_NODES) ? lcab_pkg::MAX_NODES : nc);
		if (m > lim)
			m = lim;
		base = $urandom_range(lim - m + 1, 1);
		off = ($urandom_range(3) == 0) ? $urandom_range(lcab_pkg::MAX_NODES - m) : 0;
		tree_ids.delete();
		for (int j = 0; j < m; j++) begin
			tree_ids = {tree_ids, base + j};
			if (j == 0) begin
				push_load(base, 0, off);
				dd = {dd, off};
			end else begin
				span = deep ? 1 : $urandom_range(j, 1);
				p = $urandom_range(j - 1, j - span);
				push_load(base + j, tree_ids[p], dd[p] + 1);
				dd = {dd, dd[p] + 1};
			end
			add_noise();
		end
		// a couple of lookups against the stale ancestor table
		push_query(pick_node(), pick_node());
		push_query(pick_node(), pick_node());
		push_build();
		for (int k = 0; k < nq; k++) begin
			a = pick_node();
			push_query(a, ($urandom_range(9) == 0) ? a : pick_node());
			add_noise();
		end
	endfunction

	task automatic wait_quiet();
		int rest;
		while (op_queue.size() != 0 || item_bus.valid || pending_lca.size() != 0)
			@(posedge clk);
		// a build leaves nothing to wait for, so allow its full run
		rest = 30 * ((nc_mdl > lcab_pkg::MAX_NODES) ? lcab_pkg::MAX_NODES : int'(nc_mdl)) + 100;
		repeat (rest) @(posedge clk);
	endtask

	task automatic write_node_count(input int v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {lcab_pkg::REG_NODE_COUNT, 2'b00};
		pwdata  <= lcab_pkg::APB_DW'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic run_phase(input int nc, input int idle, input int stall, input int m,
			input int nq, input bit deep, input int hold);
		wait_quiet();
		write_node_count(nc);
		idle_pct  = idle;
		stall_pct = stall;
		if (hold > 0)
			hold_request = hold;
		plant_tree(nc, m, nq, deep);
	endtask

	// item driver
	always @(negedge clk) begin : drive_item
		tree_op_t nxt;
		if (arst_n && (!item_bus.valid || item_fire)) begin
			if (op_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
				nxt = op_queue.pop_front();
				item_bus.opcode       <= nxt.opcode;
				item_bus.node_index   <= nxt.node_index;
				item_bus.parent_index <= nxt.parent_index;
				item_bus.node_depth   <= nxt.node_depth;
				item_bus.query_a      <= nxt.query_a;
				item_bus.query_b      <= nxt.query_b;
				item_bus.valid        <= 1'b1;
			end else begin
				item_bus.valid <= 1'b0;
			end
		end
	end

	// result ready, with a one-shot long hold-off to back the engine up
	always @(negedge clk) begin : drive_ready
		if (hold_request > 0 && !hold_used) begin
			hold_left = hold_request;
			hold_used = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// monitor: predict on accepted items, check accepted results
	always @(posedge clk) begin : watch_ports
		logic [lcab_pkg::NODE_W-1:0] want;
		logic                        res_fire;
		logic                        apb_fire;
		if (arst_n) begin
			item_fire = item_bus.valid && item_bus.ready;
			res_fire  = res_bus.valid && res_bus.ready;
			apb_fire  = psel && penable && pwrite && pready;
			if (apb_fire && paddr[lcab_pkg::APB_AW-1:2] == lcab_pkg::REG_NODE_COUNT)
				nc_mdl = pwdata[lcab_pkg::NODE_W-1:0];
			if (item_fire)
				absorb_item(lcab_pkg::op_t'(item_bus.opcode), item_bus.node_index,
						item_bus.parent_index, item_bus.node_depth, item_bus.query_a,
						item_bus.query_b);
			if (res_fire) begin
				if (pending_lca.size() == 0) begin
					errors++;
					$error("common_ancestor: expected no transaction, got %0d",
							res_bus.common_ancestor);
				end else begin
					want = pending_lca.pop_front();
					if (res_bus.common_ancestor !== want) begin
						errors++;
						$error("common_ancestor: expected %0d, got %0d", want,
								res_bus.common_ancestor);
					end
				end
			end
			if (item_fire || res_fire || apb_fire)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_bus.valid = 1'b0;
		item_bus.opcode = '0;
		item_bus.node_index = '0;
		item_bus.parent_index = '0;
		item_bus.node_depth = '0;
		item_bus.query_a = '0;
		item_bus.query_b = '0;
		res_bus.ready = 1'b0;
		nc_mdl = lcab_pkg::NODE_COUNT_RESET;
		for (int k = 0; k < lcab_pkg::LEVELS; k++)
			for (int v = 0; v < lcab_pkg::SLOTS; v++)
				anc_mdl[k][v] = '0;
		for (int v = 0; v < lcab_pkg::SLOTS; v++)
			dep_mdl[v] = '0;
		known[0] = 1'b1;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: node count above the table size clamps the build
		write_node_count(2047);
		push_query(2047, lcab_pkg::MAX_NODES + 1);
		push_raw(lcab_pkg::OP_NONE, 2047, 2047, 1023, 2047, 2047);
		push_raw(lcab_pkg::OP_LOAD, 0, 5, 7, 0, 0);
		push_raw(lcab_pkg::OP_LOAD, 2047, 2047, 1023, 0, 0);
		push_load(1, 0, 0);
		push_load(lcab_pkg::MAX_NODES, 1, 1);
		push_load(2, lcab_pkg::MAX_NODES, 2);
		push_load(3, 2047, 1023);
		push_query(2, lcab_pkg::MAX_NODES);
		push_query(0, 2);
		push_build();
		push_query(2, lcab_pkg::MAX_NODES);
		push_query(2, 1);
		push_query(lcab_pkg::MAX_NODES, 2);
		push_query(3, 2);
		push_query(1, 1);
		push_load(4, 1, 1);
		push_load(5, 4, 2);
		push_build();
		push_query(5, 2);
		push_query(5, lcab_pkg::MAX_NODES);
		push_query(4, 5);
		push_query(3, lcab_pkg::MAX_NODES + 1);

		// node count, sender idle %, receiver stall %, tree size, queries, chain, hold-off
		run_phase(16, 0, 0, 12, 40, 1'b0, 0);
		run_phase(0, 72, 0, 6, 15, 1'b0, 0);
		run_phase(1, 0, 72, 4, 10, 1'b0, 0);
		run_phase(32, 0, 0, 30, 45, 1'b0, 4000);
		run_phase(2047, 14, 14, 40, 45, 1'b0, 0);
		run_phase(1024, 72, 0, 120, 35, 1'b1, 0);
		run_phase(300, 0, 72, 40, 45, 1'b0, 0);
		run_phase(700, 14, 14, 30, 40, 1'b0, 0);
		wait_quiet();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
